// ===== sv/hap_pkg.sv =====
// ----------------------------------------------------------------------------
// hap_pkg
// Shared types and constants for the header aware bit puncturer.
// ----------------------------------------------------------------------------
package hap_pkg;

  localparam int GROUP_BITS = 2;
  localparam int COUNT_BITS = 16;

  localparam int MASK_W    = 64;
  localparam int POS_W     = 6;
  localparam int PUNC_W    = 6;
  localparam int PLAIN_W   = 7;
  localparam int SKIP_W    = 16;
  localparam int LEN_W     = 7;
  localparam int CFG_IDX_W = 8;

  localparam int MAX_RES = GROUP_BITS + 1;
  localparam int RES_IDX_W = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int CMP_W = (COUNT_BITS > SKIP_W) ? COUNT_BITS : SKIP_W;

  localparam logic [CFG_IDX_W-1:0] REG_KEEP_MASK        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PUNCTURED_GROUPS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PLAIN_GROUPS     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_GROUPS      = CFG_IDX_W'(3);

  typedef struct packed {
    logic [GROUP_BITS-1:0] coded_bits;
    logic                  packet_end;
  } group_t;

  typedef struct packed {
    logic out_bit;
    logic end_mark;
    logic last_of_item;
  } kept_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0] count;
    logic [MAX_RES-1:0]   bits;
    logic [MAX_RES-1:0]   marks;
  } bundle_t;

endpackage

// ===== sv/hap_out_buf.sv =====
// ----------------------------------------------------------------------------
// hap_out_buf
// Holds one request's results; sends one per cycle while kept_ready is high.
// ----------------------------------------------------------------------------
module hap_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  hap_pkg::bundle_t load_bundle,
  output logic            can_load,
  output logic            kept_valid,
  input  logic            kept_ready,
  output hap_pkg::kept_t  kept
);
  import hap_pkg::*;

  bundle_t buf_q;
  logic    take;

  assign kept_valid        = (buf_q.count != '0);
  assign take              = kept_valid && kept_ready;
  assign can_load          = (buf_q.count == '0) ||
                             ((buf_q.count == RES_CNT_W'(1)) && kept_ready);
  assign kept.out_bit      = buf_q.bits[0];
  assign kept.end_mark     = buf_q.marks[0];
  assign kept.last_of_item = (buf_q.count == RES_CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_q.count <= '0;
    end else if (load) begin
      buf_q <= load_bundle;
    end else if (take) begin
      buf_q.count <= buf_q.count - RES_CNT_W'(1);
      buf_q.bits  <= buf_q.bits >> 1;
      buf_q.marks <= buf_q.marks >> 1;
    end
  end

endmodule

// ===== sv/header_aware_bit_puncturer.sv =====
// ----------------------------------------------------------------------------
// header_aware_bit_puncturer
// Punctures coded bit groups after a header, holds one bit to mark block end.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  group    | group_valid/ready      | group (coded_bits, packet_end)
//  kept     | kept_valid/ready       | kept (out_bit, end_mark, last_of_item)
//  cfg      | cfg_valid/ready        | cfg_index, cfg_data
//
//  A group is processed in the cycle it is taken; its 0 to GROUP_BITS+1
//  results drain from the result buffer at one per cycle while kept_ready
//  is high; the result port sets the rate.
//  The next group is taken in the cycle the last result leaves.
//  Reset clears mode, counters and hold; registers take their reset values.
//  A stalled kept port holds the buffer and stops new groups.
// ----------------------------------------------------------------------------
module header_aware_bit_puncturer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      group_valid,
  output logic                      group_ready,
  input  hap_pkg::group_t           group,
  output logic                      kept_valid,
  input  logic                      kept_ready,
  output hap_pkg::kept_t            kept,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hap_pkg::MASK_W-1:0]    cfg_data
);
  import hap_pkg::*;

  logic [MASK_W-1:0]     keep_mask;
  logic [PUNC_W-1:0]     punctured_groups;
  logic [PLAIN_W-1:0]    plain_groups;
  logic [SKIP_W-1:0]     skip_groups;

  logic                  puncturing;
  logic [COUNT_BITS-1:0] header_count;
  logic [POS_W-1:0]      group_index;
  logic                  end_seen;
  logic                  hold_valid;
  logic                  held_bit;

  logic                  puncturing_next;
  logic [COUNT_BITS-1:0] header_count_next;
  logic [POS_W-1:0]      group_index_next;
  logic                  end_seen_next;
  logic                  hold_valid_next;
  logic                  held_bit_next;

  bundle_t               bundle_next;
  logic                  can_load;
  logic                  fire;

  assign cfg_ready   = 1'b1;
  assign group_ready = can_load;
  assign fire        = group_valid && group_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_mask        <= '1;
      punctured_groups <= PUNC_W'(1);
      plain_groups     <= PLAIN_W'(1);
      skip_groups      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEEP_MASK:        keep_mask        <= cfg_data;
        REG_PUNCTURED_GROUPS: punctured_groups <= cfg_data[PUNC_W-1:0];
        REG_PLAIN_GROUPS:     plain_groups     <= cfg_data[PLAIN_W-1:0];
        REG_SKIP_GROUPS:      skip_groups      <= cfg_data[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic                 punct_now;
    logic                 h;
    logic                 hb;
    logic [RES_CNT_W-1:0] n;
    logic [POS_W-1:0]     pos;
    logic                 keep;
    logic [LEN_W-1:0]     len;
    logic [LEN_W-1:0]     gi1;
    punct_now = puncturing ||
                ((group_index == '0) &&
                 (CMP_W'(header_count) == CMP_W'(skip_groups)));
    h = hold_valid;
    hb = held_bit;
    n = '0;
    bundle_next = '0;
    for (int b = 0; b < GROUP_BITS; b++) begin
      pos  = POS_W'(int'(group_index) * GROUP_BITS + b);
      keep = !punct_now || keep_mask[pos];
      if (keep) begin
        if (h) begin
          bundle_next.bits[n[RES_IDX_W-1:0]] = hb;
          n = n + RES_CNT_W'(1);
        end
        hb = group.coded_bits[b];
        h  = 1'b1;
      end
    end
    header_count_next = (header_count == '1) ? header_count
                                             : header_count + COUNT_BITS'(1);
    end_seen_next   = end_seen || group.packet_end;
    puncturing_next = punct_now;
    len = punct_now ? LEN_W'(punctured_groups) : plain_groups;
    if (len == '0) begin
      len = LEN_W'(1);
    end else if (len > LEN_W'(64)) begin
      len = LEN_W'(64);
    end
    gi1 = LEN_W'(group_index) + LEN_W'(1);
    group_index_next = gi1[POS_W-1:0];
    if (gi1 >= len) begin
      group_index_next = '0;
      if (end_seen_next) begin
        if (h) begin
          bundle_next.bits[n[RES_IDX_W-1:0]]  = hb;
          bundle_next.marks[n[RES_IDX_W-1:0]] = 1'b1;
          n  = n + RES_CNT_W'(1);
          h  = 1'b0;
          hb = 1'b0;
        end
        puncturing_next   = 1'b0;
        header_count_next = '0;
        end_seen_next     = 1'b0;
      end
    end
    hold_valid_next   = h;
    held_bit_next     = hb;
    bundle_next.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      puncturing   <= 1'b0;
      header_count <= '0;
      group_index  <= '0;
      end_seen     <= 1'b0;
      hold_valid   <= 1'b0;
      held_bit     <= 1'b0;
    end else if (fire) begin
      puncturing   <= puncturing_next;
      header_count <= header_count_next;
      group_index  <= group_index_next;
      end_seen     <= end_seen_next;
      hold_valid   <= hold_valid_next;
      held_bit     <= held_bit_next;
    end
  end

  hap_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .load        (fire),
    .load_bundle (bundle_next),
    .can_load    (can_load),
    .kept_valid  (kept_valid),
    .kept_ready  (kept_ready),
    .kept        (kept)
  );

  a_hold_empty_clear: assert property (@(posedge clk) disable iff (rst)
    !hold_valid |-> !held_bit)
    else $error("held bit set with empty hold");

  a_mark_is_last: assert property (@(posedge clk) disable iff (rst)
    kept_valid && kept.end_mark |-> kept.last_of_item)
    else $error("end mark on a result that is not the last of its request");

  a_end_mid_block: assert property (@(posedge clk) disable iff (rst)
    end_seen |-> (group_index != '0))
    else $error("pending packet end at block start");

endmodule
